// File: src/fcwl_pkg.sv
// Package for the front-coded word lookup: opcodes, register indexes,
// sequencer state type and fixed widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fcwl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int ADDR_IN_W  = 18;
  localparam int RED_W      = 34;   // widest address sum before wrapping
  localparam int SLOT_W     = 5;    // 32 key / word slots

  localparam logic [1:0] OP_STORE  = 2'd0;
  localparam logic [1:0] OP_CHAR   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_VALID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BKT_ENTRIES    = 3'd5;

  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_HYPHEN = 8'h2d;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WR_RED,
    S_STRIP,
    S_BS_TEST,
    S_BA_RED,
    S_BA_RD,
    S_BA_WT,
    S_EA_RED,
    S_HDR_RD,
    S_HDR_WT,
    S_SUF_TEST,
    S_SUF_WT,
    S_ID_RD,
    S_ID_WT,
    S_CMP,
    S_SC_MUL,
    S_SC_CNT,
    S_SC_TEST,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

// File: src/fcwl_if.sv
// Valid/ready channel interfaces for input items, results and register writes.
// Depends on fcwl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface fcwl_in_if import fcwl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [ADDR_IN_W-1:0] store_address;
  logic [7:0]           data_byte;
  modport source (output valid, opcode, store_address, data_byte, input ready);
  modport sink   (input valid, opcode, store_address, data_byte, output ready);
endinterface

interface fcwl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] word_id;
  modport source (output valid, word_id, input ready);
  modport sink   (input valid, word_id, output ready);
endinterface

interface fcwl_cfg_if import fcwl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/fcwl_addr_wrap.sv
// Iterative reduction of a wide byte address modulo the store depth.
// Depends on fcwl_pkg; for a power-of-two depth, done follows start in the next cycle.
`timescale 1ns / 1ps
`default_nettype none
module fcwl_addr_wrap import fcwl_pkg::*; #(
  parameter int STORE_DEPTH = 262144
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [RED_W-1:0]               value,
  output logic                                done,
  output logic [$clog2(STORE_DEPTH)-1:0]      result
);
  localparam int  AW   = $clog2(STORE_DEPTH);
  localparam bit  POW2 = (STORE_DEPTH & (STORE_DEPTH - 1)) == 0;
  localparam int  SHN  = RED_W - AW + 2;     // trial shifts of the depth
  localparam int  SW   = $clog2(SHN + 1);
  localparam int  WW   = RED_W + 2;

  logic [RED_W-1:0] v_r;
  logic [SW-1:0]    s_r;
  logic             busy_r, done_r;
  logic [WW-1:0]    trial;

  assign trial  = WW'(STORE_DEPTH) << s_r;
  assign done   = done_r;
  assign result = v_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= value;
        s_r    <= SW'(SHN - 1);
        busy_r <= !POW2;
        done_r <= POW2;
      end else if (busy_r) begin
        if (WW'(v_r) >= trial) begin
          v_r <= RED_W'(WW'(v_r) - trial);
        end
        if (s_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          s_r <= s_r - SW'(1);
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: src/front_coded_word_lookup.sv
// Front-coded bucketed dictionary lookup, top level.
// Depends on fcwl_pkg, fcwl_if and fcwl_addr_wrap.
// Usage:
//   in_if  carries items: opcode 0 writes data_byte into the byte store at
//          store_address, opcode 1 appends a key character (normalised:
//          upper to lower case, only letters, digits, apostrophe, hyphen,
//          at most MAX_WORD-1 kept), opcode 2 ends the word and looks it up.
//   out_if carries one word_id per lookup (0 when not found / no table).
//   cfg_if writes the six table registers; always ready, use while idle.
// Operation:
//   opcode 1 is taken in the idle state; opcode 0 waits in S_WR_RED for the
//   address wrap, then writes the byte at the wrapped address.
//   A lookup is a byte-serial walk of the single store port with registered
//   reads: a binary search over bucket_count buckets, each probe reading 4
//   index bytes, 2 header bytes, the suffix and 2 id bytes before a key
//   compare; then one index read and, per entry of the bucket scan, 2 + 2
//   header and id bytes, the suffix and a key compare.
//   One item is in work at a time; in_if.ready is high only when idle.
// Reset clears the key, the registers (bucket size to 16) and the output.
// The store is not cleared. A stalled receiver holds the result register;
// a following lookup waits at its end until that transfer completes, while
// store writes and characters still go through.
`timescale 1ns / 1ps
`default_nettype none
module front_coded_word_lookup import fcwl_pkg::*; #(
  parameter int STORE_DEPTH = 262144,
  parameter int MAX_WORD    = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fcwl_in_if.sink   in_if,
  fcwl_out_if.source out_if,
  fcwl_cfg_if.sink  cfg_if
);
  localparam int AW = $clog2(STORE_DEPTH);

  // configuration registers
  logic        table_valid_r;
  logic [17:0] index_offset_r, entries_offset_r;
  logic [15:0] entry_count_r, bucket_count_r;
  logic [7:0]  bkt_entries_r;

  // byte store, single port, registered read
  logic [7:0]    store_mem [STORE_DEPTH];
  logic [7:0]    rdata_r;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    wdata_r;

  // key and decoded word
  logic [7:0]        key_buf [32];
  logic [7:0]        dec_word [32];
  logic [SLOT_W-1:0] key_len_r, klen_r, idx_r;
  logic              dw_we;
  logic [SLOT_W-1:0] dw_idx;
  logic [7:0]        dw_data;

  // sequencer
  state_t        state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_inc;
  logic [15:0]   lo_r, hi_r, mid;
  logic [1:0]    bcnt_r;
  logic [31:0]   off_r;
  logic [15:0]   hdr_r, ident_r, res_r;
  logic [23:0]   first_r, rem;
  logic [7:0]    cnt_r, k_r;
  logic          scan_r;
  logic          out_valid_r;
  logic [15:0]   out_word_r;

  // address wrap unit
  logic             red_start, red_done;
  logic [RED_W-1:0] red_val;
  logic [AW-1:0]    red_res;

  fcwl_addr_wrap #(.STORE_DEPTH(STORE_DEPTH)) u_wrap (
    .clk(clk), .rst_n(rst_n), .start(red_start), .value(red_val),
    .done(red_done), .result(red_res)
  );

  logic       in_xfer, out_free;
  logic [7:0] ch, ka, kb, key_rd;
  logic       ch_keep, cmp_stop;
  logic [4:0] wlen;

  assign in_xfer      = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.word_id = out_word_r;
  assign out_free     = !out_valid_r || out_if.ready;

  assign ptr_inc = (ptr_r == AW'(STORE_DEPTH - 1)) ? '0 : ptr_r + AW'(1);
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign wlen    = hdr_r[9:5];
  assign rem     = 24'(entry_count_r) - first_r;

  // character normalisation
  always_comb begin
    ch = in_if.data_byte;
    if (ch >= 8'h41 && ch <= 8'h5a) ch = ch + 8'd32;
    ch_keep = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h30 && ch <= 8'h39) ||
              ch == CH_APOS || ch == CH_HYPHEN;
  end

  // key buffer read: last kept char while stripping, else compare slot
  assign key_rd = key_buf[(state_r == S_STRIP) ? klen_r - SLOT_W'(1) : idx_r];
  assign ka = dec_word[idx_r];
  assign kb = (idx_r < klen_r) ? key_rd : 8'd0;
  assign cmp_stop = (ka == 8'd0) || (ka != kb) || (idx_r == SLOT_W'(31));

  always_comb begin
    state_nxt = state_r;
    red_start = 1'b0;
    red_val   = '0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = ptr_r;
    dw_we     = 1'b0;
    dw_idx    = idx_r;
    dw_data   = rdata_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_if.opcode)
            OP_STORE: begin
              red_start = 1'b1;
              red_val   = RED_W'(in_if.store_address);
              state_nxt = S_WR_RED;
            end
            OP_LOOKUP: state_nxt = table_valid_r ? S_STRIP : S_FINISH;
            default: ;
          endcase
        end
      end
      S_WR_RED: begin
        if (red_done) begin
          mem_we    = 1'b1;
          mem_addr  = red_res;
          state_nxt = S_IDLE;
        end
      end
      S_STRIP: begin
        if (klen_r != '0 && (key_rd == CH_APOS || key_rd == CH_HYPHEN)) state_nxt = S_STRIP;
        else if (klen_r == '0) state_nxt = S_FINISH;
        else state_nxt = S_BS_TEST;
      end
      S_BS_TEST: begin
        if (lo_r < hi_r) begin
          red_start = 1'b1;
          red_val   = RED_W'(index_offset_r) + RED_W'({mid, 2'b00});
          state_nxt = S_BA_RED;
        end else if (lo_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SC_MUL;
        end
      end
      S_BA_RED: if (red_done) state_nxt = S_BA_RD;
      S_BA_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_BA_WT;
      end
      S_BA_WT: begin
        if (bcnt_r == 2'd3) begin
          red_start = 1'b1;
          red_val   = RED_W'(entries_offset_r) + RED_W'({rdata_r, off_r[31:8]});
          state_nxt = S_EA_RED;
        end else begin
          state_nxt = S_BA_RD;
        end
      end
      S_EA_RED: if (red_done) state_nxt = scan_r ? S_SC_TEST : S_HDR_RD;
      S_HDR_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_HDR_WT;
      end
      S_HDR_WT: state_nxt = (bcnt_r == 2'd1) ? S_SUF_TEST : S_HDR_RD;
      S_SUF_TEST: begin
        if (idx_r < wlen) begin
          mem_re    = 1'b1;
          state_nxt = S_SUF_WT;
        end else begin
          dw_we     = 1'b1;
          dw_idx    = wlen;
          dw_data   = 8'd0;
          state_nxt = S_ID_RD;
        end
      end
      S_SUF_WT: begin
        dw_we     = 1'b1;
        state_nxt = S_SUF_TEST;
      end
      S_ID_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_ID_WT;
      end
      S_ID_WT: state_nxt = (bcnt_r == 2'd1) ? S_CMP : S_ID_RD;
      S_CMP: begin
        if (cmp_stop) begin
          if (scan_r) state_nxt = (ka == kb) ? S_FINISH : S_SC_TEST;
          else state_nxt = S_BS_TEST;
        end
      end
      S_SC_MUL: state_nxt = S_SC_CNT;
      S_SC_CNT: begin
        red_start = 1'b1;
        red_val   = RED_W'(index_offset_r) + RED_W'({lo_r, 2'b00});
        state_nxt = S_BA_RED;
      end
      S_SC_TEST: state_nxt = (k_r < cnt_r) ? S_HDR_RD : S_FINISH;
      S_FINISH: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // store memory
  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_addr] <= wdata_r;
    if (mem_re) rdata_r <= store_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (dw_we) dec_word[dw_idx] <= dw_data;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_xfer) begin
      wdata_r <= in_if.data_byte;
      klen_r  <= key_len_r;
      res_r   <= '0;
    end
    if (mem_re) ptr_r <= ptr_inc;
    case (state_r)
      S_STRIP: begin
        if (klen_r != '0 && (key_rd == CH_APOS || key_rd == CH_HYPHEN)) begin
          klen_r <= klen_r - SLOT_W'(1);
        end
        lo_r   <= '0;
        hi_r   <= bucket_count_r;
        scan_r <= 1'b0;
      end
      S_BS_TEST: begin
        if (!(lo_r < hi_r)) lo_r <= lo_r - 16'd1;
        bcnt_r <= '0;
      end
      S_BA_RED: if (red_done) ptr_r <= red_res;
      S_BA_WT: begin
        off_r  <= {rdata_r, off_r[31:8]};
        bcnt_r <= bcnt_r + 2'd1;
      end
      S_EA_RED: begin
        if (red_done) ptr_r <= red_res;
        bcnt_r <= '0;
      end
      S_HDR_WT: begin
        hdr_r  <= {rdata_r, hdr_r[15:8]};
        bcnt_r <= bcnt_r + 2'd1;
        if (bcnt_r == 2'd1) idx_r <= hdr_r[12:8];
      end
      S_SUF_TEST: if (!(idx_r < wlen)) bcnt_r <= '0;
      S_SUF_WT: idx_r <= idx_r + SLOT_W'(1);
      S_ID_WT: begin
        ident_r <= {rdata_r, ident_r[15:8]};
        bcnt_r  <= bcnt_r + 2'd1;
        if (bcnt_r == 2'd1) idx_r <= '0;
      end
      S_CMP: begin
        if (cmp_stop) begin
          if (scan_r) begin
            if (ka == kb) res_r <= ident_r;
            k_r <= k_r + 8'd1;
          end else if (ka <= kb) begin
            lo_r <= mid + 16'd1;
          end else begin
            hi_r <= mid;
          end
        end else begin
          idx_r <= idx_r + SLOT_W'(1);
        end
      end
      S_SC_MUL: first_r <= 24'(lo_r) * 24'(bkt_entries_r);
      S_SC_CNT: begin
        if (first_r >= 24'(entry_count_r)) cnt_r <= '0;
        else if (rem > 24'(bkt_entries_r)) cnt_r <= bkt_entries_r;
        else cnt_r <= rem[7:0];
        k_r    <= '0;
        scan_r <= 1'b1;
      end
      // next scanned entry starts its header read from the first byte
      S_SC_TEST: bcnt_r <= '0;
      default: ;
    endcase
  end

  // key capture; every lookup clears the key when its result is handed on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= '0;
    end else if (state_r == S_FINISH && out_free) begin
      key_len_r <= '0;
    end else if (state_r == S_IDLE && in_xfer && in_if.opcode == OP_CHAR &&
                 key_len_r < SLOT_W'(MAX_WORD - 1) && ch_keep) begin
      key_len_r <= key_len_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_xfer && in_if.opcode == OP_CHAR &&
        key_len_r < SLOT_W'(MAX_WORD - 1) && ch_keep) begin
      key_buf[key_len_r] <= ch;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FINISH && out_free) begin
      out_valid_r <= 1'b1;
      out_word_r  <= res_r;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_valid_r    <= 1'b0;
      index_offset_r   <= '0;
      entries_offset_r <= '0;
      entry_count_r    <= '0;
      bucket_count_r   <= '0;
      bkt_entries_r    <= 8'd16;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_TABLE_VALID:    table_valid_r    <= cfg_if.data[0];
        CFG_INDEX_OFFSET:   index_offset_r   <= cfg_if.data;
        CFG_ENTRIES_OFFSET: entries_offset_r <= cfg_if.data;
        CFG_ENTRY_COUNT:    entry_count_r    <= cfg_if.data[15:0];
        CFG_BUCKET_COUNT:   bucket_count_r   <= cfg_if.data[15:0];
        CFG_BKT_ENTRIES:    bkt_entries_r    <= cfg_if.data[7:0];
        default: ;
      endcase
    end
  end

  // checks
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_if.opcode == OP_LOOKUP) |=> state_r != S_IDLE)
    else $error("lookup transfer did not start a lookup");
  a_wrap_owner: assert property (@(posedge clk) disable iff (!rst_n)
    red_done |-> (state_r == S_WR_RED || state_r == S_BA_RED || state_r == S_EA_RED))
    else $error("address wrap finished with no waiting state");
  a_key_cap: assert property (@(posedge clk) disable iff (!rst_n)
    key_len_r <= SLOT_W'(MAX_WORD - 1))
    else $error("key length beyond cap");
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> (out_valid_r && key_len_r == '0))
    else $error("finished lookup gave no result");
endmodule
`default_nettype wire
